// ===== src/lir_pkg.sv =====
`default_nettype none
package lir_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int MAX_CHANNELS = 2;

    localparam int FRAC_BITS  = 16;
    localparam int STEP_W     = 21;
    localparam int PHASE_W    = 21;
    localparam int PH_W       = PHASE_W + 1;
    localparam int CHAN_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 21;
    localparam int PROD_W     = SAMPLE_BITS + FRAC_BITS + 2;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
    localparam logic [STEP_W-1:0] MIN_STEP   = STEP_W'(8192);
    localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(2);

    localparam logic [PH_W-1:0] ONE_PH = PH_W'(1) << FRAC_BITS;
    localparam logic [PH_W-1:0] TWO_PH = PH_W'(2) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_STEP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CHAN = CFG_IDX_W'(1);

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic mul;
        logic lerp_emit;
        logic copy_emit;
        logic sub_one;
        logic hold;
        logic store_phase;
        logic copy_done;
    } lir_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic held_valid;
        logic ph_lt_one;
        logic last;
        logic out_free;
    } lir_status_t;

endpackage
`default_nettype wire

// ===== src/lir_in_if.sv =====
`default_nettype none
interface lir_in_if import lir_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_0;
    logic signed [SAMPLE_BITS-1:0] sample_1;
    logic                          block_last;

    modport source (output valid, output sample_0, output sample_1, output block_last,
                    input ready);
    modport sink   (input valid, input sample_0, input sample_1, input block_last,
                    output ready);
endinterface
`default_nettype wire

// ===== src/lir_out_if.sv =====
`default_nettype none
interface lir_out_if import lir_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_0;
    logic signed [SAMPLE_BITS-1:0] out_1;
    logic                          run_end;

    modport source (output valid, output out_0, output out_1, output run_end,
                    input ready);
    modport sink   (input valid, input out_0, input out_1, input run_end,
                    output ready);
endinterface
`default_nettype wire

// ===== src/lir_ctrl.sv =====
`default_nettype none
module lir_ctrl import lir_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire lir_status_t status,
    output lir_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LTEST = 3'd1;
    localparam logic [2:0] S_LOUT  = 3'd2;
    localparam logic [2:0] S_HOLD  = 3'd3;
    localparam logic [2:0] S_COPY  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.held_valid ? S_LTEST : S_HOLD;
                end
            end
            S_LTEST:
            begin
                if (status.ph_lt_one)
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_LOUT;
                end
                else
                begin
                    cmd.sub_one = 1'b1;
                    state_next  = S_HOLD;
                end
            end
            S_LOUT:
            begin
                if (status.out_free)
                begin
                    cmd.lerp_emit = 1'b1;
                    state_next    = S_LTEST;
                end
            end
            S_HOLD:
            begin
                cmd.hold = 1'b1;
                if (status.last)
                begin
                    state_next = S_COPY;
                end
                else
                begin
                    cmd.store_phase = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_COPY:
            begin
                if (status.ph_lt_one)
                begin
                    cmd.copy_emit = status.out_free;
                end
                else
                begin
                    cmd.copy_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |=> state_reg == S_LOUT)
        else $error("multiply not followed by output state");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_done |=> state_reg == S_IDLE)
        else $error("copy run did not return to idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sub_one |=> state_reg == S_HOLD)
        else $error("phase wrap not followed by hold state");

endmodule
`default_nettype wire

// ===== src/lir_datapath.sv =====
`default_nettype none
module lir_datapath import lir_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_we,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data,
    input  wire lir_cmd_t         cmd,
    output lir_status_t           status,
    lir_in_if.sink                in_frame,
    lir_out_if.source             out_frame
);

    logic [STEP_W-1:0]             step_reg;
    logic [CHAN_W-1:0]             chan_reg;
    logic signed [SAMPLE_BITS-1:0] held0_reg;
    logic signed [SAMPLE_BITS-1:0] held1_reg;
    logic                          held_valid_reg;
    logic [PHASE_W-1:0]            phase_acc_reg;
    logic [PH_W-1:0]               ph_reg;
    logic signed [SAMPLE_BITS-1:0] new0_reg;
    logic signed [SAMPLE_BITS-1:0] new1_reg;
    logic                          last_reg;
    logic signed [PROD_W-1:0]      prod0_reg;
    logic signed [PROD_W-1:0]      prod1_reg;
    logic signed [SAMPLE_BITS-1:0] out0_reg;
    logic signed [SAMPLE_BITS-1:0] out1_reg;
    logic                          run_end_reg;
    logic                          out_valid_reg;

    logic                          stereo;
    logic [STEP_W-1:0]             step_eff;
    logic [PH_W-1:0]               ph_sum;
    logic [PH_W-1:0]               ph_minus;
    logic signed [SAMPLE_BITS:0]   diff0;
    logic signed [SAMPLE_BITS:0]   diff1;
    logic signed [FRAC_BITS:0]     frac;
    logic signed [PROD_W:0]        rnd0;
    logic signed [PROD_W:0]        rnd1;
    logic signed [PROD_W:0]        q0;
    logic signed [PROD_W:0]        q1;
    logic signed [SAMPLE_BITS-1:0] lerp0;
    logic signed [SAMPLE_BITS-1:0] lerp1;
    logic                          lerp_end;
    logic                          copy_end;
    logic                          out_load;

    assign stereo   = (chan_reg >= CHAN_W'(2)) && (MAX_CHANNELS >= 2);
    assign step_eff = (step_reg < MIN_STEP) ? MIN_STEP : step_reg;
    assign ph_sum   = ph_reg + PH_W'(step_eff);
    assign ph_minus = ph_reg - ONE_PH;

    assign diff0 = $signed({new0_reg[SAMPLE_BITS-1], new0_reg})
                 - $signed({held0_reg[SAMPLE_BITS-1], held0_reg});
    assign diff1 = $signed({new1_reg[SAMPLE_BITS-1], new1_reg})
                 - $signed({held1_reg[SAMPLE_BITS-1], held1_reg});
    assign frac  = $signed({1'b0, ph_reg[FRAC_BITS-1:0]});

    // round to nearest, ties up
    assign rnd0  = PROD_W'(prod0_reg) + (PROD_W + 1)'(1 << (FRAC_BITS - 1));
    assign rnd1  = PROD_W'(prod1_reg) + (PROD_W + 1)'(1 << (FRAC_BITS - 1));
    assign q0    = rnd0 >>> FRAC_BITS;
    assign q1    = rnd1 >>> FRAC_BITS;
    assign lerp0 = held0_reg + q0[SAMPLE_BITS-1:0];
    assign lerp1 = stereo ? (held1_reg + q1[SAMPLE_BITS-1:0]) : '0;

    assign lerp_end = (ph_sum >= ONE_PH) && (!last_reg || (ph_sum >= TWO_PH));
    assign copy_end = (ph_sum >= ONE_PH);
    assign out_load = cmd.lerp_emit || cmd.copy_emit;

    assign status.in_valid   = in_frame.valid;
    assign status.held_valid = held_valid_reg;
    assign status.ph_lt_one  = ph_reg < ONE_PH;
    assign status.last       = last_reg;
    assign status.out_free   = !out_valid_reg || out_frame.ready;

    assign in_frame.ready    = cmd.in_ready;
    assign out_frame.valid   = out_valid_reg;
    assign out_frame.out_0   = out0_reg;
    assign out_frame.out_1   = out1_reg;
    assign out_frame.run_end = run_end_reg;

    // config and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_RESET;
            chan_reg       <= CHAN_RESET;
            held0_reg      <= '0;
            held1_reg      <= '0;
            held_valid_reg <= 1'b0;
            phase_acc_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_STEP))
            begin
                step_reg <= cfg_data[STEP_W-1:0];
            end
            if (cfg_we && (cfg_index == REG_CHAN))
            begin
                chan_reg <= cfg_data[CHAN_W-1:0];
            end
            if (cmd.hold)
            begin
                held0_reg      <= new0_reg;
                held1_reg      <= new1_reg;
                held_valid_reg <= 1'b1;
            end
            if (cmd.copy_done)
            begin
                held_valid_reg <= 1'b0;
                phase_acc_reg  <= ph_minus[PHASE_W-1:0];
            end
            if (cmd.store_phase)
            begin
                phase_acc_reg <= ph_reg[PHASE_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            new0_reg <= in_frame.sample_0;
            new1_reg <= stereo ? in_frame.sample_1 : '0;
            last_reg <= in_frame.block_last;
            ph_reg   <= PH_W'(phase_acc_reg);
        end
        else if (cmd.sub_one || cmd.copy_done)
        begin
            ph_reg <= ph_minus;
        end
        else if (out_load)
        begin
            ph_reg <= ph_sum;
        end
        if (cmd.mul)
        begin
            prod0_reg <= PROD_W'(frac * diff0);
            prod1_reg <= PROD_W'(frac * diff1);
        end
        if (cmd.lerp_emit)
        begin
            out0_reg    <= lerp0;
            out1_reg    <= lerp1;
            run_end_reg <= lerp_end;
        end
        else if (cmd.copy_emit)
        begin
            out0_reg    <= new0_reg;
            out1_reg    <= new1_reg;
            run_end_reg <= copy_end;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (ph_reg < ONE_PH))
        else $error("result emitted with phase at or past one");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_frame.ready))
        else $error("pending result overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_done |=> !held_valid_reg)
        else $error("held frame still valid after block end");

endmodule
`default_nettype wire

// ===== src/linear_interp_resampler.sv =====
// a result is registered after the request is captured, through LTEST and LOUT when interpolated,
// or through HOLD and COPY for a held copy, after a skip from LTEST to HOLD if one comes first;
// interpolated results then alternate between LTEST and LOUT, held copies follow every cycle
// while the output is free, and a frame with nothing to emit is only stored through HOLD
// reset: step 65536, stereo, no frame held, phase zero, output empty
`default_nettype none
module linear_interp_resampler import lir_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_data,
    lir_in_if.sink               in_frame,
    lir_out_if.source            out_frame
);

    lir_cmd_t    cmd;
    lir_status_t status;

    lir_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    lir_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .in_frame  (in_frame),
        .out_frame (out_frame)
    );

endmodule
`default_nettype wire

// ===== tb/sv/lir_resample_checker.sv =====
`timescale 1ns / 100ps
module lir_resample_checker import lir_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_data,
    lir_in_if                    in_ch,
    lir_out_if                   out_ch,
    output int                   mismatches,
    output int                   outstanding
);

    localparam int unsigned UNIT_PHASE  = 32'd1 << FRAC_BITS;
    localparam int          MAX_RESULTS = 16;
    localparam int          PRINT_LIMIT = 60;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_0;
        logic signed [SAMPLE_BITS-1:0] out_1;
        logic                          run_end;
    } resample_out_t;

    resample_out_t                 expected_q[$];
    logic [STEP_W-1:0]             step_reg   = STEP_RESET;
    logic [CHAN_W-1:0]             chan_reg   = CHAN_RESET;
    logic signed [SAMPLE_BITS-1:0] held_0     = '0;
    logic signed [SAMPLE_BITS-1:0] held_1     = '0;
    logic                          held_ok    = 1'b0;
    logic [PHASE_W-1:0]            read_phase = '0;
    int                            fail_tally = 0;
    int                            due_count  = 0;

    assign mismatches  = fail_tally;
    assign outstanding = due_count;

    task automatic report_mismatch(input string msg);
        fail_tally++;
        if (fail_tally <= PRINT_LIMIT)
            $display("%0t ns: %s", $time, msg);
    endtask

    // held + frac * (new - held), rounded to nearest with ties upward
    function automatic logic signed [SAMPLE_BITS-1:0] lerp_q16(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b,
        input int unsigned                   frac
    );
        longint prod;
        prod = longint'(frac) * (longint'(b) - longint'(a));
        return SAMPLE_BITS'(longint'(a) + ((prod + 64'sd32768) >>> FRAC_BITS));
    endfunction

    task automatic predict_frame(
        input logic signed [SAMPLE_BITS-1:0] s0,
        input logic signed [SAMPLE_BITS-1:0] s1,
        input logic                          last
    );
        resample_out_t                 frame_out[MAX_RESULTS];
        logic                          stereo;
        logic signed [SAMPLE_BITS-1:0] n0;
        logic signed [SAMPLE_BITS-1:0] n1;
        int unsigned                   stp;
        int unsigned                   ph;
        int                            n;
        stereo = (chan_reg >= 2) && (MAX_CHANNELS >= 2);
        stp    = (step_reg < MIN_STEP) ? int'(MIN_STEP) : int'(step_reg);
        n0     = s0;
        n1     = stereo ? s1 : '0;
        ph     = int'(read_phase);
        n      = 0;
        if (held_ok)
        begin
            while (ph < UNIT_PHASE && n < MAX_RESULTS)
            begin
                frame_out[n].out_0   = lerp_q16(held_0, n0, ph);
                frame_out[n].out_1   = stereo ? lerp_q16(held_1, n1, ph) : '0;
                frame_out[n].run_end = 1'b0;
                n++;
                ph += stp;
            end
            ph -= UNIT_PHASE;
        end
        held_0  = n0;
        held_1  = n1;
        held_ok = 1'b1;
        // copies of the last frame of a block
        if (last)
        begin
            while (ph < UNIT_PHASE && n < MAX_RESULTS)
            begin
                frame_out[n].out_0   = n0;
                frame_out[n].out_1   = n1;
                frame_out[n].run_end = 1'b0;
                n++;
                ph += stp;
            end
            ph -= UNIT_PHASE;
            held_ok = 1'b0;
        end
        read_phase = PHASE_W'(ph);
        for (int k = 0; k < n; k++)
        begin
            frame_out[k].run_end = (k == n - 1);
            expected_q.push_back(frame_out[k]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        resample_out_t want;
        if (!rst_n)
        begin
            step_reg   = STEP_RESET;
            chan_reg   = CHAN_RESET;
            held_0     = '0;
            held_1     = '0;
            held_ok    = 1'b0;
            read_phase = '0;
            expected_q.delete();
            due_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STEP: step_reg = cfg_data[STEP_W-1:0];
                    REG_CHAN: chan_reg = cfg_data[CHAN_W-1:0];
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                predict_frame(in_ch.sample_0, in_ch.sample_1, in_ch.block_last);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch($sformatf("result with nothing expected: %0d %0d %0d",
                                              out_ch.out_0, out_ch.out_1, out_ch.run_end));
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_ch.out_0 !== want.out_0)
                        report_mismatch($sformatf("out_0 got %0d expected %0d",
                                                  out_ch.out_0, want.out_0));
                    if (out_ch.out_1 !== want.out_1)
                        report_mismatch($sformatf("out_1 got %0d expected %0d",
                                                  out_ch.out_1, want.out_1));
                    if (out_ch.run_end !== want.run_end)
                        report_mismatch($sformatf("run_end got %0b expected %0b",
                                                  out_ch.run_end, want.run_end));
                end
            end
            due_count <= expected_q.size();
        end
    end

endmodule

// ===== tb/sv/linear_interp_resampler_tb.sv =====
`timescale 1ns / 100ps
module linear_interp_resampler_tb;
    import lir_pkg::*;

    localparam int LIMIT_CYCLES  = 500000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;

    localparam logic [SAMPLE_BITS-1:0] MAX_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] MAX_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_STEP;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int cycle_cnt    = 0;
    int hold_left    = 0;
    bit hold_tog     = 1'b0;
    bit hold_seen    = 1'b0;
    int fail_count;
    int results_due;

    lir_in_if  in_ch();
    lir_out_if out_ch();

    linear_interp_resampler i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_frame  (in_ch),
        .out_frame (out_ch)
    );

    lir_resample_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .mismatches  (fail_count),
        .outstanding (results_due)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_tog != hold_seen)
        begin
            hold_seen = hold_tog;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        if ($urandom_range(3) == 0)
        begin
            case ($urandom_range(3))
                0:       return MAX_POS;
                1:       return MAX_NEG;
                2:       return '0;
                default: return '1;
            endcase
        end
        return SAMPLE_BITS'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_step();
        case ($urandom_range(9))
            0:       return CFG_DATA_W'($urandom_range(int'(MIN_STEP) - 1));
            1:       return $urandom_range(1) ? '1 : CFG_DATA_W'(1048576);
            2:       return CFG_DATA_W'($urandom_range(2097151, 262144));
            default: return CFG_DATA_W'($urandom_range(131072, int'(MIN_STEP)));
        endcase
    endfunction

    // entered and left at a falling edge; valid stays high after the request
    task automatic send_frame(
        input logic [SAMPLE_BITS-1:0] s0,
        input logic [SAMPLE_BITS-1:0] s1,
        input logic                   last
    );
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.sample_0   <= s0;
        in_ch.sample_1   <= s1;
        in_ch.block_last <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic end_traffic();
        in_ch.valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(
        input logic [CFG_DATA_W-1:0] step,
        input logic [CFG_DATA_W-1:0] chans
    );
        cfg_we    <= 1'b1;
        cfg_index <= REG_STEP;
        cfg_data  <= step;
        @(negedge clk);
        cfg_index <= REG_CHAN;
        cfg_data  <= chans;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_block(input int len);
        for (int i = 0; i < len; i++)
            send_frame(rand_sample(), rand_sample(), i == len - 1);
    endtask

    task automatic run_regime(input int idle_pct, input int stall_pct, input int n_req,
                              input bit squeeze);
        int sent;
        int len;
        sent         = 0;
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        if (squeeze)
        begin
            end_traffic();
            set_config(CFG_DATA_W'(MIN_STEP), CFG_DATA_W'(2));
            hold_tog = ~hold_tog;
        end
        while (sent < n_req)
        begin
            if (sent > 0 && $urandom_range(4) == 0)
            begin
                end_traffic();
                set_config(rand_step(), CFG_DATA_W'($urandom_range(3)));
            end
            len = ($urandom_range(7) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
            send_block(len);
            sent += len;
        end
    endtask

    initial
    begin
        in_ch.valid      = 1'b0;
        in_ch.sample_0   = '0;
        in_ch.sample_1   = '0;
        in_ch.block_last = 1'b0;
        out_ch.ready     = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        tx_idle_pct  = 33;
        rx_stall_pct = 57;

        // reset settings: unit step, stereo, first frame only stored
        send_frame(MAX_POS, MAX_NEG, 1'b0);
        send_frame(MAX_NEG, MAX_POS, 1'b0);
        send_frame('0, '1, 1'b0);
        send_frame('1, SAMPLE_BITS'(1), 1'b1);
        send_frame(SAMPLE_BITS'(16'h1234), SAMPLE_BITS'(16'hEDCC), 1'b1);
        end_traffic();

        // zero step is raised to the minimum, mono
        set_config('0, CFG_DATA_W'(1));
        send_frame(MAX_POS, SAMPLE_BITS'(16'h1111), 1'b0);
        send_frame(MAX_NEG, SAMPLE_BITS'(16'h2222), 1'b0);
        send_frame(MAX_POS, SAMPLE_BITS'(16'h3333), 1'b1);
        end_traffic();

        // half-way fractions with odd differences, channel count three
        set_config(CFG_DATA_W'(98304), CFG_DATA_W'(3));
        send_frame('0, '0, 1'b0);
        send_frame(SAMPLE_BITS'(3), SAMPLE_BITS'(-3), 1'b0);
        send_frame(MAX_NEG, MAX_POS, 1'b0);
        send_frame(MAX_POS, MAX_NEG, 1'b1);
        end_traffic();

        // carry longer than a block, channel count zero
        set_config(CFG_DATA_W'(1048576), '0);
        for (int i = 0; i < 6; i++)
            send_frame(i[0] ? MAX_NEG : MAX_POS, SAMPLE_BITS'(i), i == 2 || i == 5);
        end_traffic();

        set_config('1, CFG_DATA_W'(2));
        send_frame(MAX_POS, MAX_POS, 1'b1);
        send_frame(MAX_NEG, MAX_NEG, 1'b1);
        send_frame('1, '0, 1'b1);

        run_regime(33, 57, 50, 1'b0);
        run_regime(57, 33, 50, 1'b0);
        run_regime(0, 0, 50, 1'b1);
        end_traffic();

        if (fail_count == 0 && results_due == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
src/lir_pkg.sv
src/lir_in_if.sv
src/lir_out_if.sv
src/lir_ctrl.sv
src/lir_datapath.sv
src/linear_interp_resampler.sv
tb/sv/lir_resample_checker.sv
tb/sv/linear_interp_resampler_tb.sv
